// File: design/mm64_pkg.sv
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared types, constants and helpers for the 64-bit string hash block.
// ----------------------------------------------------------------------------
package mm64_pkg;

    // hash constants
    localparam logic [63:0] MUL_M       = 64'hc6a4a7935bd1e995;
    localparam int unsigned SHIFT_R     = 47;
    localparam int unsigned LENGTH_BITS = 32;

    // input beat: one little-endian word of the string
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  bytes_valid;
        logic [31:0] total_length;
        logic        last_word;
    } t_in_beat;

    // output beat: finished hash of one string
    typedef struct packed {
        logic [63:0] hash_value;
        logic        length_mismatch;
    } t_out_beat;

    // request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_mul_req;

    // response from the shared multiplier
    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } t_mul_rsp;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DISPATCH,
        S_MIX_A,
        S_MIX_B,
        S_MIX_C,
        S_TAIL,
        S_FINAL,
        S_DONE
    } t_state;

    // keep the low nbytes bytes of a word
    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < nbytes) begin
                mask[8*i +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

    // xor-shift step of the mix
    function automatic logic [63:0] xor_shift(input logic [63:0] value);
        return value ^ (value >> SHIFT_R);
    endfunction

endpackage

// File: design/mm64_mul_unit.sv
// ----------------------------------------------------------------------------
// mm64_mul_unit
// Iterative multiply by the hash constant, low 64 bits of the product.
// One 32x32 multiplier, three partial products computed one after another.
// ----------------------------------------------------------------------------
module mm64_mul_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mm64_pkg::t_mul_req i_req,
    output mm64_pkg::t_mul_rsp o_rsp
);

    localparam logic [31:0] M_LO = mm64_pkg::MUL_M[31:0];
    localparam logic [31:0] M_HI = mm64_pkg::MUL_M[63:32];

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_x;
    logic [63:0] r_prod;
    logic [63:0] r_acc;

    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_pp;

    // operand halves for the current partial product
    always_comb begin
        w_a  = (r_step == 2'd2) ? r_x[63:32] : r_x[31:0];
        w_b  = (r_step == 2'd1) ? M_HI : M_LO;
        w_pp = 64'(w_a) * 64'(w_b);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_req.operand;
        end else if (r_busy) begin
            case (r_step)
                2'd0: begin
                    r_prod <= w_pp;
                end
                2'd1: begin
                    r_acc  <= r_prod;
                    r_prod <= w_pp;
                end
                2'd2: begin
                    r_acc  <= r_acc + {r_prod[31:0], 32'd0};
                    r_prod <= w_pp;
                end
                default: begin
                    r_acc  <= r_acc + {r_prod[31:0], 32'd0};
                end
            endcase
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// File: design/murmur64a_string_hash.sv
// ----------------------------------------------------------------------------
// murmur64a_string_hash
// 64-bit MurmurHash64A of a byte string fed as little-endian 8-byte words.
// ----------------------------------------------------------------------------
// multiplications per word, m: first word of a string +1 (length), full word +3,
//   partial word +1, last word +1 (m = 0..5); they run one after another on
//   the shared multiplier, and a hash leaves after its last word's final one
// input: a new word is accepted only in idle, once all multiplies of the previous
//   word are done; after a last word, only once its hash has gone to the output
// reset: synchronous active low; clears the sequencer, seed and message state
// ----------------------------------------------------------------------------
module murmur64a_string_hash #(
    parameter int unsigned LENGTH_BITS = mm64_pkg::LENGTH_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mm64_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mm64_pkg::t_out_beat o_out_beat
);

    localparam int unsigned LB = LENGTH_BITS;

    mm64_pkg::t_state    r_state, n_state;
    logic [31:0]         r_seed;
    logic [63:0]         r_hash, n_hash;
    logic [LB-1:0]       r_seen, n_seen;
    logic [LB-1:0]       r_stated, n_stated;
    logic                r_await, n_await;
    logic [63:0]         r_word, n_word;
    logic [3:0]          r_nbytes, n_nbytes;
    logic                r_last, n_last;
    logic                r_mul_start, n_mul_start;
    logic [63:0]         r_mul_opnd, n_mul_opnd;
    logic                r_out_valid, n_out_valid;
    mm64_pkg::t_out_beat r_out_beat, n_out_beat;

    mm64_pkg::t_mul_req  w_mul_req;
    mm64_pkg::t_mul_rsp  w_mul_rsp;
    logic                w_in_acc;
    logic                w_slot_free;
    logic [3:0]          w_nbytes;
    logic [63:0]         w_len_ext;
    logic [LB-1:0]       w_len;
    logic [63:0]         w_stated64;
    logic [LB-1:0]       w_base;
    logic [LB:0]         w_sum;
    logic [63:0]         w_prod;

    // shared constant multiplier
    assign w_mul_req.start   = r_mul_start;
    assign w_mul_req.operand = r_mul_opnd;

    mm64_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign w_prod = w_mul_rsp.product;

    // handshake outputs
    always_comb begin
        o_in_stall  = (r_state != mm64_pkg::S_IDLE);
        o_out_valid = r_out_valid;
        o_out_beat  = r_out_beat;
    end

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // input beat decode: clamp byte count, mask stated length
    always_comb begin
        w_nbytes   = i_in_beat.bytes_valid[3] ? 4'd8 : i_in_beat.bytes_valid;
        w_len_ext  = {32'd0, i_in_beat.total_length};
        w_len      = w_len_ext[LB-1:0];
        w_stated64 = '0;
        w_stated64[LB-1:0] = w_len;
        w_base     = r_await ? '0 : r_seen;
        w_sum      = {1'b0, w_base} + (LB+1)'(w_nbytes);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mm64_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_await ? mm64_pkg::S_INIT : mm64_pkg::S_DISPATCH;
                end
            end
            mm64_pkg::S_INIT: begin
                if (w_mul_rsp.done) n_state = mm64_pkg::S_DISPATCH;
            end
            mm64_pkg::S_DISPATCH: begin
                if (r_nbytes == 4'd8) begin
                    n_state = mm64_pkg::S_MIX_A;
                end else if (r_nbytes != 4'd0) begin
                    n_state = mm64_pkg::S_TAIL;
                end else if (r_last) begin
                    n_state = mm64_pkg::S_FINAL;
                end else begin
                    n_state = mm64_pkg::S_IDLE;
                end
            end
            mm64_pkg::S_MIX_A: begin
                if (w_mul_rsp.done) n_state = mm64_pkg::S_MIX_B;
            end
            mm64_pkg::S_MIX_B: begin
                if (w_mul_rsp.done) n_state = mm64_pkg::S_MIX_C;
            end
            mm64_pkg::S_MIX_C, mm64_pkg::S_TAIL: begin
                if (w_mul_rsp.done) begin
                    n_state = r_last ? mm64_pkg::S_FINAL : mm64_pkg::S_IDLE;
                end
            end
            mm64_pkg::S_FINAL: begin
                if (w_mul_rsp.done) n_state = mm64_pkg::S_DONE;
            end
            mm64_pkg::S_DONE: begin
                if (w_slot_free) n_state = mm64_pkg::S_IDLE;
            end
            default: begin
                n_state = mm64_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and multiplier launches
    always_comb begin
        n_hash      = r_hash;
        n_seen      = r_seen;
        n_stated    = r_stated;
        n_await     = r_await;
        n_word      = r_word;
        n_nbytes    = r_nbytes;
        n_last      = r_last;
        n_mul_start = 1'b0;
        n_mul_opnd  = r_mul_opnd;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_beat  = r_out_beat;
        case (r_state)
            mm64_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_word   = i_in_beat.data_word;
                    n_nbytes = w_nbytes;
                    n_last   = i_in_beat.last_word;
                    n_seen   = w_sum[LB] ? '1 : w_sum[LB-1:0];
                    if (r_await) begin
                        n_stated    = w_len;
                        n_await     = 1'b0;
                        n_mul_start = 1'b1;
                        n_mul_opnd  = w_stated64;
                    end
                end
            end
            mm64_pkg::S_INIT: begin
                if (w_mul_rsp.done) n_hash = {32'd0, r_seed} ^ w_prod;
            end
            mm64_pkg::S_DISPATCH: begin
                if (r_nbytes == 4'd8) begin
                    n_mul_start = 1'b1;
                    n_mul_opnd  = r_word;
                end else if (r_nbytes != 4'd0) begin
                    n_mul_start = 1'b1;
                    n_mul_opnd  = r_hash ^ (r_word & mm64_pkg::byte_mask(r_nbytes));
                end else if (r_last) begin
                    n_mul_start = 1'b1;
                    n_mul_opnd  = mm64_pkg::xor_shift(r_hash);
                end
            end
            mm64_pkg::S_MIX_A: begin
                if (w_mul_rsp.done) begin
                    n_mul_start = 1'b1;
                    n_mul_opnd  = mm64_pkg::xor_shift(w_prod);
                end
            end
            mm64_pkg::S_MIX_B: begin
                if (w_mul_rsp.done) begin
                    n_mul_start = 1'b1;
                    n_mul_opnd  = r_hash ^ w_prod;
                end
            end
            mm64_pkg::S_MIX_C, mm64_pkg::S_TAIL: begin
                if (w_mul_rsp.done) begin
                    n_hash = w_prod;
                    if (r_last) begin
                        n_mul_start = 1'b1;
                        n_mul_opnd  = mm64_pkg::xor_shift(w_prod);
                    end
                end
            end
            mm64_pkg::S_FINAL: begin
                if (w_mul_rsp.done) n_hash = mm64_pkg::xor_shift(w_prod);
            end
            mm64_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid                = 1'b1;
                    n_out_beat.hash_value      = r_hash;
                    n_out_beat.length_mismatch = (r_seen != r_stated);
                    n_hash                     = '0;
                    n_seen                     = '0;
                    n_stated                   = '0;
                    n_await                    = 1'b1;
                end
            end
            default: begin
                n_await = 1'b1;
            end
        endcase
    end

    // control and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm64_pkg::S_IDLE;
            r_seed      <= '0;
            r_hash      <= '0;
            r_seen      <= '0;
            r_stated    <= '0;
            r_await     <= 1'b1;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_seen      <= n_seen;
            r_stated    <= n_stated;
            r_await     <= n_await;
            r_mul_start <= n_mul_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_seed <= i_cfg_wr_data;
        end
    end

    // beat payload and multiplier operand
    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_nbytes   <= n_nbytes;
        r_last     <= n_last;
        r_mul_opnd <= n_mul_opnd;
        r_out_beat <= n_out_beat;
    end

endmodule
